// ----- design/wrc_pkg.sv -----
// ----------------------------------------------------------------------------
// wrc_pkg
// shared constants and types of the windowed range convergence detector
// ----------------------------------------------------------------------------
`default_nettype none

package wrc_pkg;

   // lane count and window depth (depth is a power of two)
   localparam int NUM_LANES    = 8;
   localparam int WINDOW_DEPTH = 8;

   localparam int MAX_LANES  = 8;
   localparam int RANGE_W    = 16;
   localparam int ADDR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W      = RANGE_W + ADDR_W;
   localparam int DATA_W     = MAX_LANES * RANGE_W;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_THRESHOLD = 1'b0;
   localparam logic [RANGE_W-1:0] THRESHOLD_RESET = 16'd50;

   // control shared by all lanes
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] raddr;
      logic              acc_vld;
      logic              acc_first;
   } lane_ctrl_type;

   // what a lane reports to the merge stage
   typedef struct packed {
      logic               ok;
      logic [RANGE_W-1:0] mean;
   } lane_status_type;

endpackage

`default_nettype wire

// ----- design/windowed_range_convergence.sv -----
// sequence: an item that fills the window, or any later one, passes the SCAN, DRAIN and DONE
//   states; before the first wrap an item goes straight to DONE with a not-converged result
// flow: a new item is taken only in IDLE, once the last result is in the output register; the
//   scan reads one entry per cycle from each lane's window ram read port
// reset: synchronous, clears slot, full flag, state and output valid, threshold to 50
// ----------------------------------------------------------------------------
// windowed_range_convergence
// per-anchor ring windows with parallel lane scans for spread and mean
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_range_convergence (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // range_0 .. range_7, 16 bits each, range_0 lowest
   input  wire logic [wrc_pkg::DATA_W-1:0]        req_tdata,
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // mean_0 .. mean_7, 16 bits each, mean_0 lowest
   output logic [wrc_pkg::DATA_W-1:0]             rsp_tdata,
   // converged
   output logic                                   rsp_tuser,
   // csr port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [wrc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [wrc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wrc_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [wrc_pkg::ADDR_W-1:0] LAST_SLOT =
      wrc_pkg::ADDR_W'(wrc_pkg::WINDOW_DEPTH - 1);

   logic [1:0]                   state_ff, state_in;
   logic [wrc_pkg::ADDR_W-1:0]   slot_ff, slot_in;     // next ring slot to write
   logic                         full_ff, full_in;     // window has wrapped once
   logic [wrc_pkg::ADDR_W-1:0]   cnt_ff, cnt_in;       // scan read address
   logic                         rd_vld_ff;            // ram read data valid this cycle
   logic                         rd_first_ff;          // that data is slot zero
   logic [wrc_pkg::RANGE_W-1:0]  thr_ff;

   logic                         accept;
   logic                         csr_sel;
   logic                         load;
   wrc_pkg::lane_ctrl_type       ctrl;
   wrc_pkg::lane_status_type [wrc_pkg::NUM_LANES-1:0] status;

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   // word index decode, byte offset bits ignored
   assign csr_sel    = (csr_paddr[wrc_pkg::CSR_ADDR_W-1:2] == wrc_pkg::REG_THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= wrc_pkg::THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel) begin
         thr_ff <= csr_pwdata[wrc_pkg::RANGE_W-1:0];
      end
   end

   assign csr_prdata = csr_sel ? wrc_pkg::CSR_DATA_W'(thr_ff) : '0;

   // ---------------- sequencer ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // result goes into the output register once it is free
   assign load       = (state_ff == ST_DONE) && (!rsp_tvalid || rsp_tready);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      full_in  = full_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in = slot_ff + wrc_pkg::ADDR_W'(1);
               cnt_in  = '0;
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  full_in  = 1'b1;
                  state_in = ST_SCAN;
               end else if (full_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  // window not yet full: not-converged result right away
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + wrc_pkg::ADDR_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read word is accumulated at the end of this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         slot_ff     <= '0;
         full_ff     <= 1'b0;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         slot_ff     <= slot_in;
         full_ff     <= full_in;
         cnt_ff      <= cnt_in;
         rd_vld_ff   <= (state_ff == ST_SCAN);
         rd_first_ff <= (state_ff == ST_SCAN) && (cnt_ff == '0);
      end
   end

   // shared lane control: write the new reading, then sweep the window
   assign ctrl.we        = accept;
   assign ctrl.waddr     = slot_ff;
   assign ctrl.raddr     = cnt_ff;
   assign ctrl.acc_vld   = rd_vld_ff;
   assign ctrl.acc_first = rd_first_ff;

   // ---------------- lanes ----------------
   for (genvar g = 0; g < wrc_pkg::NUM_LANES; g++) begin : g_lane
      wrc_lane u_lane (
         .clock       (clock),
         .ctrl        (ctrl),
         .range_value (req_tdata[g*wrc_pkg::RANGE_W +: wrc_pkg::RANGE_W]),
         .threshold   (thr_ff),
         .status      (status[g])
      );
   end

   // ---------------- merge and output register ----------------
   wrc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .window_full (full_ff),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- design/wrc_ram.sv -----
// ----------------------------------------------------------------------------
// wrc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/wrc_lane.sv -----
// ----------------------------------------------------------------------------
// wrc_lane
// one anchor lane: ring window in ram, serial max / min / sum scan
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_lane (
   input  wire logic                          clock,
   input  wire wrc_pkg::lane_ctrl_type        ctrl,
   input  wire logic [wrc_pkg::RANGE_W-1:0]   range_value,
   input  wire logic [wrc_pkg::RANGE_W-1:0]   threshold,
   output wrc_pkg::lane_status_type           status
);

   logic [wrc_pkg::RANGE_W-1:0] rdata;
   logic [wrc_pkg::RANGE_W-1:0] hi_ff, hi_in;
   logic [wrc_pkg::RANGE_W-1:0] lo_ff, lo_in;
   logic [wrc_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [wrc_pkg::RANGE_W-1:0] spread;

   wrc_ram #(
      .WIDTH (wrc_pkg::RANGE_W),
      .DEPTH (wrc_pkg::WINDOW_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ctrl.we),
      .waddr (ctrl.waddr),
      .wdata (range_value),
      .raddr (ctrl.raddr),
      .rdata (rdata)
   );

   always_comb begin
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      sum_in = sum_ff;
      if (ctrl.acc_vld) begin
         if (ctrl.acc_first) begin
            hi_in  = rdata;
            lo_in  = rdata;
            sum_in = wrc_pkg::SUM_W'(rdata);
         end else begin
            if (rdata > hi_ff) hi_in = rdata;
            if (rdata < lo_ff) lo_in = rdata;
            sum_in = sum_ff + wrc_pkg::SUM_W'(rdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      sum_ff <= sum_in;
   end

   assign spread      = hi_ff - lo_ff;
   assign status.ok   = (spread <= threshold);
   // divide by the power of two depth
   assign status.mean = sum_ff[wrc_pkg::SUM_W-1 -: wrc_pkg::RANGE_W];

endmodule

`default_nettype wire

// ----- design/wrc_merge.sv -----
// ----------------------------------------------------------------------------
// wrc_merge
// combines lane verdicts into one result item and holds it for the output
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_merge (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            load,
   input  wire logic                                            window_full,
   input  wire wrc_pkg::lane_status_type [wrc_pkg::NUM_LANES-1:0] status,
   input  wire logic                                            rsp_tready,
   output logic                                                 rsp_tvalid,
   output logic [wrc_pkg::DATA_W-1:0]                           rsp_tdata,
   output logic                                                 rsp_tuser
);

   logic [wrc_pkg::MAX_LANES-1:0][wrc_pkg::RANGE_W-1:0] mean_vec;
   logic [wrc_pkg::NUM_LANES-1:0]                       ok_vec;
   logic                                                conv;
   logic                                                valid_ff, valid_in;
   logic [wrc_pkg::DATA_W-1:0]                          data_ff;
   logic                                                conv_ff;

   for (genvar g = 0; g < wrc_pkg::MAX_LANES; g++) begin : g_lane
      if (g < wrc_pkg::NUM_LANES) begin : g_used
         assign mean_vec[g] = status[g].mean;
         assign ok_vec[g]   = status[g].ok;
      end else begin : g_unused
         assign mean_vec[g] = '0;
      end
   end

   assign conv = window_full & (&ok_vec);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= conv ? wrc_pkg::DATA_W'(mean_vec) : '0;
         conv_ff <= conv;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = conv_ff;

endmodule

`default_nettype wire

// ----- design/wrc_checker.sv -----
// ----------------------------------------------------------------------------
// wrc_checker
// port level checks of the convergence detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tvalid,
   input wire logic                         req_tready,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [wrc_pkg::DATA_W-1:0]   rsp_tdata,
   input wire logic                         rsp_tuser
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // a not-converged result carries zero means
   a_zero_means: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("means not zero on not-converged result");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted back to back");

   // reset empties the output register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind windowed_range_convergence wrc_checker u_wrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
